// ----- sv/bitmap_range_run_engine_assert.svh -----
// Assertion macros shared by the bitmap range/run engine modules.
`ifndef BITMAP_RANGE_RUN_ENGINE_ASSERT_SVH
`define BITMAP_RANGE_RUN_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brr assertion failed");

// Next-cycle implication, disabled during reset.
`define BRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brr assertion failed");

`endif

// ----- sv/brr_pkg.sv -----
// Package: types, constants and helper functions of the bitmap range/run engine.
package brr_pkg;

  localparam int MAP_WORDS = 64;
  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LEN_W     = 13;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAP_WORDS * WORD_BITS);
  localparam logic [LEN_W-1:0] ACC_MAX = 13'h1FFF;

  localparam logic [1:0] REQ_WRITE     = 2'd0;
  localparam logic [1:0] REQ_RUN       = 2'd1;
  localparam logic [1:0] REQ_INTERSECT = 2'd2;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        bit_value;
    logic [11:0] start_req;
    logic [12:0] stop;
    logic [5:0]  word_index;
    logic [63:0] other_word;
    logic        last_word;
  } brr_in_t;

  typedef struct packed {
    logic [12:0] run_length;
    logic        run_value;
    logic [12:0] match_count;
    logic        count_done;
  } brr_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic iand;
    logic icnt;
    logic emit;
  } brr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       no_work;
    logic       walk_done;
  } brr_sts_t;

  // Index of the lowest set bit; 0 when none is set.
  function automatic logic [5:0] ffs64(input logic [63:0] x);
    logic [2:0] sel;
    logic [2:0] pos;
    logic [7:0] byte_v;
    sel = '0;
    pos = '0;
    for (int i = 7; i >= 0; i--) begin
      if (|x[i*8 +: 8]) sel = 3'(i);
    end
    byte_v = x[sel*8 +: 8];
    for (int j = 7; j >= 0; j--) begin
      if (byte_v[j]) pos = 3'(j);
    end
    return {sel, pos};
  endfunction

  function automatic logic [6:0] popcount64(input logic [63:0] x);
    logic [3:0] cnt [8];
    logic [6:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        cnt[i] = cnt[i] + 4'(x[i*8 + j]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      sum = sum + 7'(cnt[i]);
    end
    return sum;
  endfunction

endpackage

// ----- sv/brr_ctrl.sv -----
// Controller state machine of the bitmap range/run engine.
`include "bitmap_range_run_engine_assert.svh"

module brr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  brr_pkg::brr_sts_t sts_i,
  output brr_pkg::brr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_IAND  = 3'd3;
  localparam logic [2:0] S_ICNT  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts_i.no_work) begin
          state_d = S_RESP;
        end else if (sts_i.kind == brr_pkg::REQ_INTERSECT) begin
          state_d = S_IAND;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) state_d = S_RESP;
      end
      S_IAND: begin
        cmd_o.iand = 1'b1;
        state_d    = S_ICNT;
      end
      S_ICNT: begin
        cmd_o.icnt = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BRR_ASSERT_NEXT(a_accept_fetch, in_valid_i && in_ready_o, state_q == S_FETCH)
  `BRR_ASSERT_IMPL(a_rise_from_resp, $rose(out_valid_o), $past(state_q) == S_RESP)
  `BRR_ASSERT_NEXT(a_walk_end, state_q == S_WALK && sts_i.walk_done, state_q == S_RESP)

endmodule

// ----- sv/brr_datapath.sv -----
// Datapath of the bitmap range/run engine: bitmap memory, word walk, intersect count.
`include "bitmap_range_run_engine_assert.svh"

module brr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [12:0]       cfg_data_i,
  input  brr_pkg::brr_in_t  in_req_i,
  input  brr_pkg::brr_cmd_t cmd_i,
  output brr_pkg::brr_sts_t sts_o,
  output brr_pkg::brr_out_t out_rsp_o
);

  localparam int AW = brr_pkg::ADDR_W;
  localparam int BW = brr_pkg::BIT_W;
  localparam int LW = brr_pkg::LEN_W;

  logic [brr_pkg::WORD_BITS-1:0] mem [brr_pkg::MAP_WORDS];
  logic [brr_pkg::MAP_WORDS-1:0] valid_q;

  logic [brr_pkg::WORD_BITS-1:0] rd_q, rdw, wd, mask_word_q, len_mask, wr_mask;
  logic                          rd_vld_q, we;
  logic [AW-1:0]                 ra;

  brr_pkg::brr_in_t  req_q;
  brr_pkg::brr_out_t res_q, out_rsp_q;

  logic [LW-1:0] active_bits_q, len_c, len_q, stop_c, stopm1;
  logic          skip_q, oob_q, run_val_q;
  logic [AW-1:0] ptr_q, lastw_q;
  logic [BW-1:0] stop_lo_q;
  logic [LW-1:0] acc_q;

  // word walk
  logic          first_w, last_w, b_cur, found, run_done;
  logic [BW-1:0] lo, hi, f;
  logic [63:0]   diffw;
  logic [LW-1:0] pos, word_end, run_end, base;
  logic [6:0]    len_diff;

  // intersect count
  logic [LW:0]   acc_sum;
  logic [LW-1:0] acc_sat;

  assign cfg_ready_o = 1'b1;
  assign out_rsp_o   = out_rsp_q;

  assign len_c  = (active_bits_q > brr_pkg::LEN_MAX) ? brr_pkg::LEN_MAX : active_bits_q;
  assign stop_c = (in_req_i.stop > len_c) ? len_c : in_req_i.stop;
  assign stopm1 = stop_c - LW'(1);

  assign rdw = rd_q & {brr_pkg::WORD_BITS{rd_vld_q}};
  assign ra  = cmd_i.walk ? AW'(ptr_q + AW'(1)) : ptr_q;

  // range write mask
  assign first_w = (ptr_q == req_q.start_req[11:6]);
  assign last_w  = (ptr_q == lastw_q);
  assign lo      = first_w ? req_q.start_req[5:0] : '0;
  assign hi      = last_w ? stop_lo_q : '1;
  assign wr_mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (BW'(63) - hi));

  // run scan: first bit that differs from the run value
  assign b_cur    = first_w ? rdw[req_q.start_req[5:0]] : run_val_q;
  assign diffw    = (rdw ^ {64{b_cur}}) & ({64{1'b1}} << lo);
  assign found    = |diffw;
  assign f        = brr_pkg::ffs64(diffw);
  assign pos      = {1'b0, ptr_q, f};
  assign word_end = {7'({1'b0, ptr_q}) + 7'd1, 6'd0};
  assign run_end  = (found && (pos < len_q)) ? pos : len_q;
  assign run_done = found || (word_end >= len_q);

  // active-length mask for an intersect word
  assign base     = {1'b0, ptr_q, 6'd0};
  assign len_diff = 7'(len_q - base);
  always_comb begin
    if (len_q >= word_end) begin
      len_mask = '1;
    end else if (len_q <= base) begin
      len_mask = '0;
    end else begin
      len_mask = {64{1'b1}} >> 6'(7'd64 - len_diff);
    end
  end

  always_comb begin
    we = 1'b0;
    wd = rdw;
    if (cmd_i.walk && req_q.req_type == brr_pkg::REQ_WRITE) begin
      we = 1'b1;
      wd = req_q.bit_value ? (rdw | wr_mask) : (rdw & ~wr_mask);
    end else if (cmd_i.iand) begin
      we = 1'b1;
      wd = rdw & req_q.other_word;
    end
  end

  assign acc_sum = {1'b0, acc_q} + (LW+1)'(brr_pkg::popcount64(mask_word_q));
  assign acc_sat = (acc_sum > {1'b0, brr_pkg::ACC_MAX}) ? brr_pkg::ACC_MAX : acc_sum[LW-1:0];

  assign sts_o.kind      = req_q.req_type;
  assign sts_o.no_work   = (req_q.req_type == brr_pkg::REQ_UNUSED)
                        || (req_q.req_type == brr_pkg::REQ_WRITE && skip_q)
                        || (req_q.req_type == brr_pkg::REQ_RUN && oob_q);
  assign sts_o.walk_done = (req_q.req_type == brr_pkg::REQ_WRITE) ? last_w : run_done;

  always_ff @(posedge clk_i) begin
    if (we) mem[ptr_q] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      rd_vld_q      <= 1'b0;
      active_bits_q <= brr_pkg::LEN_MAX;
      acc_q         <= '0;
    end else begin
      if (we) valid_q[ptr_q] <= 1'b1;
      rd_vld_q <= valid_q[ra];
      if (cfg_valid_i) active_bits_q <= cfg_data_i;
      if (cmd_i.icnt) acc_q <= req_q.last_word ? '0 : acc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= in_req_i;
      len_q     <= len_c;
      skip_q    <= ({1'b0, in_req_i.start_req} >= stop_c);
      oob_q     <= ({1'b0, in_req_i.start_req} >= len_c);
      lastw_q   <= stopm1[11:6];
      stop_lo_q <= stopm1[5:0];
      ptr_q     <= (in_req_i.req_type == brr_pkg::REQ_INTERSECT) ? in_req_i.word_index
                                                                : in_req_i.start_req[11:6];
      res_q     <= '0;
    end
    if (cmd_i.walk) begin
      ptr_q     <= AW'(ptr_q + AW'(1));
      run_val_q <= b_cur;
      if (req_q.req_type == brr_pkg::REQ_RUN && run_done) begin
        res_q.run_length <= run_end - {1'b0, req_q.start_req};
        res_q.run_value  <= b_cur;
      end
    end
    if (cmd_i.iand) mask_word_q <= wd & len_mask;
    if (cmd_i.icnt) begin
      res_q.match_count <= acc_sat;
      res_q.count_done  <= req_q.last_word;
    end
    if (cmd_i.emit) out_rsp_q <= res_q;
  end

  `BRR_ASSERT_IMPL(a_write_in_range, cmd_i.walk && req_q.req_type == brr_pkg::REQ_WRITE, ptr_q <= lastw_q)
  `BRR_ASSERT_IMPL(a_done_clears_acc, cmd_i.emit && res_q.count_done, acc_q == '0)
  `BRR_ASSERT_IMPL(a_run_within_len, cmd_i.walk && run_done && req_q.req_type == brr_pkg::REQ_RUN, run_end <= len_q)

endmodule

// ----- sv/bitmap_range_run_engine.sv -----
// Bitmap range/run engine: a 64 x 64-bit bitmap in a single-port-read memory,
// walked one word per cycle. An item with no work (unknown type, empty range
// write, query at or past the active length) goes straight from its fetch to
// the result; an intersect word is read, ANDed and written back, then counted
// by popcount; a range write or run query walks the W words that it covers
// (1 to 64), one bitmap read per cycle. A new item is taken
// once the previous one has reached the output register, so the next item can
// start while a result waits to be taken. Reset clears the bitmap at once
// through per-word valid bits; there is no clearing pass. The active_bits
// register (reset 4096, capped at 4096) is written through the cfg channel.
module bitmap_range_run_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [12:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brr_pkg::brr_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brr_pkg::brr_out_t out_rsp_o
);

  brr_pkg::brr_cmd_t cmd;
  brr_pkg::brr_sts_t sts;

  brr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for bitmap_range_run_engine: directed and random requests checked against a bitmap tracker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brr_pkg::*;

  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned MAP_BITS = MAP_WORDS * WORD_BITS;

  // Tracks bitmap, count and active length; holds the results still owed.
  class bitmap_tracker;
    logic [WORD_BITS-1:0] words [MAP_WORDS];
    int unsigned acc;
    logic [12:0] active_bits;
    brr_out_t pending_results [$];
    int unsigned errors, checked, longest;
    int unsigned n_write, n_run, n_and, n_done, n_sat, n_other;

    function new();
      foreach (words[w]) words[w] = '0;
      acc = 0;
      active_bits = 13'd4096;
      errors = 0;
      checked = 0;
      longest = 0;
      n_write = 0;
      n_run = 0;
      n_and = 0;
      n_done = 0;
      n_sat = 0;
      n_other = 0;
    endfunction

    function int unsigned eff_len();
      return (active_bits > MAP_BITS) ? MAP_BITS : active_bits;
    endfunction

    function logic bit_at(int unsigned pos);
      return words[pos / WORD_BITS][pos % WORD_BITS];
    endfunction

    function void apply_request(brr_in_t req);
      brr_out_t rsp;
      int unsigned len, last_pos, pos, base;
      logic [WORD_BITS-1:0] mask;
      rsp = '0;
      len = eff_len();
      case (req.req_type)
        REQ_WRITE: begin
          n_write++;
          last_pos = (req.stop > len) ? len : req.stop;
          for (pos = req.start_req; pos < last_pos; pos++) begin
            words[pos / WORD_BITS][pos % WORD_BITS] = req.bit_value;
          end
        end
        REQ_RUN: begin
          n_run++;
          if (req.start_req < len) begin
            rsp.run_value = bit_at(req.start_req);
            pos = req.start_req;
            while (pos < len && bit_at(pos) == rsp.run_value) pos++;
            rsp.run_length = 13'(pos - req.start_req);
            if (pos - req.start_req > longest) longest = pos - req.start_req;
          end
        end
        REQ_INTERSECT: begin
          n_and++;
          base = req.word_index * WORD_BITS;
          words[req.word_index] &= req.other_word;
          if (len >= base + WORD_BITS) begin
            mask = '1;
          end else if (len <= base) begin
            mask = '0;
          end else begin
            mask = (64'd1 << (len - base)) - 64'd1;
          end
          acc += $countones(words[req.word_index] & mask);
          if (acc > ACC_MAX) begin
            acc = ACC_MAX;
            n_sat++;
          end
          rsp.match_count = 13'(acc);
          if (req.last_word) begin
            rsp.count_done = 1'b1;
            acc = 0;
            n_done++;
          end
        end
        default: n_other++;
      endcase
      pending_results.insert(pending_results.size(), rsp);
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_response(input brr_out_t got);
      brr_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no request pending");
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.run_length !== want.run_length)
        report_mismatch($sformatf("run_length got %0d want %0d", got.run_length,
                                  want.run_length));
      if (got.run_value !== want.run_value)
        report_mismatch($sformatf("run_value got %b want %b", got.run_value, want.run_value));
      if (got.match_count !== want.match_count)
        report_mismatch($sformatf("match_count got %0d want %0d", got.match_count,
                                  want.match_count));
      if (got.count_done !== want.count_done)
        report_mismatch($sformatf("count_done got %b want %b", got.count_done,
                                  want.count_done));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  brr_in_t     in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  brr_out_t    out_rsp_o;

  bit            no_idle;
  int unsigned   n_cfg;
  bitmap_tracker sb = new();

  bitmap_range_run_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Result side: random stall per transaction, then take the next result
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_rsp_o);
    end
  end

  task automatic drive_req(input brr_in_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.apply_request(req);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_active(input int unsigned bits);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 13'(bits);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.active_bits = 13'(bits);
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Fill every field at random; callers overwrite the ones that matter
  function automatic brr_in_t rand_req();
    brr_in_t req;
    req.req_type   = 2'($urandom_range(0, 3));
    req.bit_value  = 1'($urandom_range(0, 1));
    req.start_req  = 12'($urandom_range(0, 4095));
    req.stop       = 13'($urandom_range(0, MAP_BITS));
    req.word_index = 6'($urandom_range(0, MAP_WORDS - 1));
    req.other_word = {$urandom, $urandom};
    req.last_word  = 1'($urandom_range(0, 1));
    return req;
  endfunction

  function automatic logic [63:0] rand_other();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       return '0;
      1, 2, 3: return '1;
      4, 5, 6: return ~(a & b);
      default: return a;
    endcase
  endfunction

  function automatic int unsigned pick_pos();
    int unsigned len;
    len = sb.eff_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, MAP_WORDS - 1) * WORD_BITS;
    if (len > 0 && $urandom_range(0, 2) != 0) return $urandom_range(0, len - 1);
    return $urandom_range(0, 4095);
  endfunction

  task automatic send_range_write(input logic value, input int unsigned first,
                                  input int unsigned stop_at);
    brr_in_t req;
    req = rand_req();
    req.req_type  = REQ_WRITE;
    req.bit_value = value;
    req.start_req = 12'(first);
    req.stop      = 13'(stop_at);
    drive_req(req);
  endtask

  task automatic send_run_query(input int unsigned first);
    brr_in_t req;
    req = rand_req();
    req.req_type  = REQ_RUN;
    req.start_req = 12'(first);
    drive_req(req);
  endtask

  task automatic send_intersect(input logic [5:0] idx, input logic [63:0] other,
                                input logic last);
    brr_in_t req;
    req = rand_req();
    req.req_type   = REQ_INTERSECT;
    req.word_index = idx;
    req.other_word = other;
    req.last_word  = last;
    drive_req(req);
  endtask

  task automatic send_unknown();
    brr_in_t req;
    req = rand_req();
    req.req_type = REQ_UNUSED;
    drive_req(req);
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent, pick, first, span, stop_at, k, base;
    logic seq;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        first = pick_pos();
        case ($urandom_range(0, 19))
          0:             span = MAP_BITS;
          1, 2, 3, 4, 5: span = $urandom_range(0, 1000);
          default:       span = $urandom_range(0, 130);
        endcase
        stop_at = (first + span > MAP_BITS) ? MAP_BITS : first + span;
        if ($urandom_range(0, 9) == 0) stop_at = $urandom_range(0, MAP_BITS);
        send_range_write($urandom_range(0, 9) < 7, first, stop_at);
        sent++;
      end else if (pick < 58) begin
        send_run_query(pick_pos());
        sent++;
      end else if (pick < 85) begin
        // Intersect pass: a few words, pass closed on the last one
        k = $urandom_range(1, 6);
        base = $urandom_range(0, MAP_WORDS - 1);
        seq = 1'($urandom_range(0, 1));
        for (int j = 0; j < k; j++) begin
          send_intersect(seq ? 6'(base + j) : 6'($urandom_range(0, MAP_WORDS - 1)),
                         rand_other(), j == k - 1);
        end
        sent += k;
      end else if (pick < 93) begin
        send_intersect(6'($urandom_range(0, MAP_WORDS - 1)), rand_other(),
                       1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 98) begin
        send_unknown();
        sent++;
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    int unsigned lens [10];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    n_cfg       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full length after reset: empty map, full fill, holes, aligned stop
    send_run_query(0);
    send_run_query(4095);
    send_range_write(1'b1, 0, MAP_BITS);
    send_run_query(0);
    send_range_write(1'b0, 100, 164);
    send_range_write(1'b0, 128, 192);
    send_run_query(63);
    send_run_query(191);
    send_run_query(192);
    send_range_write(1'b1, 500, 500);
    send_range_write(1'b0, 600, 10);
    send_range_write(1'b1, 0, 0);
    send_intersect(6'd0, '1, 1'b0);
    send_intersect(6'd63, rand_other(), 1'b0);
    send_intersect(6'd5, '0, 1'b1);
    send_unknown();
    send_range_write(1'b0, 4095, MAP_BITS);
    send_run_query(4095);
    send_run_query(4094);

    // Zero length: nothing written, nothing found, nothing counted
    write_active(0);
    send_run_query(0);
    send_range_write(1'b1, 0, MAP_BITS);
    send_intersect(6'd1, '1, 1'b1);

    // Length beyond the map saturates
    write_active(8191);
    send_run_query(4000);
    send_range_write(1'b0, 4000, MAP_BITS);
    send_run_query(3999);
    send_intersect(6'd63, '1, 1'b1);

    // Mid-word length: clipped writes, masked count
    write_active(100);
    send_range_write(1'b1, 90, MAP_BITS);
    send_run_query(99);
    send_run_query(100);
    send_intersect(6'd1, '1, 1'b0);
    send_intersect(6'd0, '1, 1'b1);

    write_active(1);
    send_run_query(0);
    send_intersect(6'd0, '1, 1'b1);

    // Drive the count past its ceiling before closing the pass
    write_active(4096);
    send_range_write(1'b1, 0, MAP_BITS);
    repeat (130) send_intersect(6'($urandom_range(0, MAP_WORDS - 1)), '1, 1'b0);
    send_intersect(6'd0, '1, 1'b1);

    lens = '{4096, 4095, 64, 65, 0, 0, 1, 8191, 0, 4096};
    lens[4] = $urandom_range(1, MAP_BITS);
    lens[8] = $urandom_range(1, MAP_BITS);
    lens[5] = 0;
    for (int ph = 0; ph < 10; ph++) begin
      write_active(lens[ph]);
      no_idle = (ph % 3 == 2);
      random_traffic(145);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("covered %0d range writes, %0d run queries (longest run %0d), %0d intersect words",
             sb.n_write, sb.n_run, sb.longest, sb.n_and);
    $display("%0d passes closed, %0d saturated counts, %0d unknown requests, %0d length writes",
             sb.n_done, sb.n_sat, sb.n_other, n_cfg);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/brr_pkg.sv
sv/brr_ctrl.sv
sv/brr_datapath.sv
sv/bitmap_range_run_engine.sv
dv/tb_top.sv
